/* rtl/skt_pkg.sv */
// Package for the script keyword tokenizer: sizes, token kind codes, the
// step decision struct and the byte class / keyword match helpers.
// No dependencies.
`default_nettype none
package skt_pkg;

    localparam int WINDOW_BYTES = 8;
    localparam int OFFSET_BITS  = 16;
    localparam int MAX_RESULTS  = 10;

    localparam int WIN_BITS = WINDOW_BYTES * 8;
    localparam int CNT_BITS = $clog2(WINDOW_BYTES + 1);
    localparam int IDX_BITS = $clog2(WINDOW_BYTES);
    localparam int RES_BITS = $clog2(MAX_RESULTS + 1);
    localparam int KW_COUNT = 6;

    typedef logic [OFFSET_BITS-1:0] t_off;
    typedef logic [CNT_BITS-1:0]    t_cnt;
    typedef logic [WIN_BITS-1:0]    t_win;
    typedef logic [4:0]             t_kind;
    typedef logic [RES_BITS-1:0]    t_res;

    localparam t_off OFFSET_MAX = '1;

    typedef enum logic [1:0] {RUN_NONE, RUN_VAR, RUN_NUM, RUN_STR} t_run;
    typedef enum logic [1:0] {M_NO, M_YES, M_WAIT} t_match;

    localparam t_kind TK_VARIABLE = 5'd6;
    localparam t_kind TK_NUMBER   = 5'd7;
    localparam t_kind TK_SEMI     = 5'd8;
    localparam t_kind TK_EQUALS   = 5'd9;
    localparam t_kind TK_ARROW    = 5'd10;
    localparam t_kind TK_PLUS     = 5'd11;
    localparam t_kind TK_MUL      = 5'd12;
    localparam t_kind TK_DIV      = 5'd13;
    localparam t_kind TK_MINUS    = 5'd14;
    localparam t_kind TK_LPAREN   = 5'd15;
    localparam t_kind TK_RPAREN   = 5'd16;
    localparam t_kind TK_LBRACE   = 5'd17;
    localparam t_kind TK_RBRACE   = 5'd18;
    localparam t_kind TK_LESS     = 5'd19;
    localparam t_kind TK_GREATER  = 5'd20;
    localparam t_kind TK_LBRACKET = 5'd21;
    localparam t_kind TK_RBRACKET = 5'd22;
    localparam t_kind TK_COMMA    = 5'd23;
    localparam t_kind TK_STRING   = 5'd24;
    localparam t_kind TK_UNKNOWN  = 5'd25;
    localparam t_kind TK_EOF      = 5'd26;

    // one settle step of the window front
    typedef struct packed {
        logic  adv;
        t_cnt  pop;
        logic  emit;
        t_kind kind;
        t_off  off;
        t_off  len;
        t_run  mode;
        t_off  start;
        t_off  run_len;
    } t_step;

    function automatic t_off sat_inc(input t_off a);
        return (a == OFFSET_MAX) ? a : a + t_off'(1);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_digit(c) || ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    // byte i of a word sits at [8i+:8]; the keyword index is its token kind
    function automatic logic [55:0] kw_text(input logic [2:0] k);
        logic [55:0] t;
        case (k)
            3'd0:    t = 56'("ohce");
            3'd1:    t = 56'("rof");
            3'd2:    t = 56'("fi");
            3'd3:    t = 56'("esle");
            3'd4:    t = 56'("hcaerof");
            3'd5:    t = 56'("sa");
            default: t = 56'("php?<");
        endcase
        return t;
    endfunction

    function automatic logic [2:0] kw_len(input logic [2:0] k);
        logic [2:0] l;
        case (k)
            3'd0:    l = 3'd4;
            3'd1:    l = 3'd3;
            3'd2:    l = 3'd2;
            3'd3:    l = 3'd4;
            3'd4:    l = 3'd7;
            3'd5:    l = 3'd2;
            default: l = 3'd5;
        endcase
        return l;
    endfunction

    function automatic t_match match_word(input t_win win, input t_cnt cnt,
                                          input logic [55:0] word, input logic [2:0] len,
                                          input logic bound, input logic closed);
        t_match r;
        logic   done;
        r    = M_YES;
        done = 1'b0;
        for (int i = 0; i < 7; i++) begin
            if (!done && (3'(i) < len)) begin
                if (CNT_BITS'(i) >= cnt) begin
                    r    = closed ? M_NO : M_WAIT;
                    done = 1'b1;
                end else if (win[8*i +: 8] != word[8*i +: 8]) begin
                    r    = M_NO;
                    done = 1'b1;
                end
            end
        end
        if (!done && bound) begin
            if (CNT_BITS'(len) >= cnt) begin
                r = closed ? M_YES : M_WAIT;
            end else begin
                for (int i = 0; i < 8; i++) begin
                    if (3'(i) == len) begin
                        r = is_alnum(win[8*i +: 8]) ? M_NO : M_YES;
                    end
                end
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/skt_scan.sv */
// Settle unit: decides one step on the front of the pending window
// (run extension, run end, run start, skip, keyword, operator). Uses skt_pkg.
`default_nettype none
module skt_scan (
    input  wire skt_pkg::t_win  i_win,
    input  wire skt_pkg::t_cnt  i_count,
    input  wire                 i_closed,
    input  wire skt_pkg::t_run  i_mode,
    input  wire skt_pkg::t_off  i_start,
    input  wire skt_pkg::t_off  i_len,
    input  wire skt_pkg::t_off  i_front_off,
    output skt_pkg::t_step      o_step
);
    import skt_pkg::*;

    logic [7:0] c;
    t_match     m_php;
    t_match     m_kw [KW_COUNT];

    assign c     = i_win[7:0];
    assign m_php = match_word(i_win, i_count, kw_text(3'd7), kw_len(3'd7), 1'b0, i_closed);

    always_comb begin
        for (int k = 0; k < KW_COUNT; k++) begin
            m_kw[k] = match_word(i_win, i_count, kw_text(3'(k)), kw_len(3'(k)), 1'b1,
                                 i_closed);
        end
    end

    always_comb begin
        logic done;
        o_step         = '0;
        o_step.adv     = 1'b1;
        o_step.mode    = i_mode;
        o_step.start   = i_start;
        o_step.run_len = i_len;
        done           = 1'b0;
        if (i_mode == RUN_STR) begin
            o_step.pop = t_cnt'(1);
            if (c == "\"") begin
                o_step.emit = 1'b1;
                o_step.kind = TK_STRING;
                o_step.off  = i_start;
                o_step.len  = i_len;
                o_step.mode = RUN_NONE;
            end else begin
                o_step.run_len = sat_inc(i_len);
            end
        end else if (i_mode != RUN_NONE) begin
            if ((i_mode == RUN_VAR) ? is_alnum(c) : is_digit(c)) begin
                o_step.pop     = t_cnt'(1);
                o_step.run_len = sat_inc(i_len);
            end else begin
                // run ends; the byte stays for the next step
                o_step.emit = 1'b1;
                o_step.kind = (i_mode == RUN_VAR) ? TK_VARIABLE : TK_NUMBER;
                o_step.off  = i_start;
                o_step.len  = i_len;
                o_step.mode = RUN_NONE;
            end
        end else if (is_space(c)) begin
            o_step.pop = t_cnt'(1);
        end else if (m_php == M_WAIT) begin
            o_step.adv = 1'b0;
        end else if (m_php == M_YES) begin
            o_step.pop = t_cnt'(kw_len(3'd7));
        end else begin
            for (int k = 0; k < KW_COUNT; k++) begin
                if (!done && (m_kw[k] != M_NO)) begin
                    done = 1'b1;
                    if (m_kw[k] == M_WAIT) begin
                        o_step.adv = 1'b0;
                    end else begin
                        o_step.emit = 1'b1;
                        o_step.kind = t_kind'(k);
                        o_step.pop  = t_cnt'(kw_len(3'(k)));
                    end
                end
            end
            if (!done) begin
                o_step.pop = t_cnt'(1);
                if (c == "$") begin
                    o_step.mode    = RUN_VAR;
                    o_step.start   = sat_inc(i_front_off);
                    o_step.run_len = '0;
                end else if (is_digit(c)) begin
                    o_step.mode    = RUN_NUM;
                    o_step.start   = i_front_off;
                    o_step.run_len = t_off'(1);
                end else if (c == "\"") begin
                    o_step.mode    = RUN_STR;
                    o_step.start   = sat_inc(i_front_off);
                    o_step.run_len = '0;
                end else if (c == "=") begin
                    if (i_count < t_cnt'(2)) begin
                        o_step.adv  = i_closed;
                        o_step.emit = i_closed;
                        o_step.kind = TK_EQUALS;
                    end else if (i_win[15:8] == ">") begin
                        o_step.emit = 1'b1;
                        o_step.kind = TK_ARROW;
                        o_step.pop  = t_cnt'(2);
                    end else begin
                        o_step.emit = 1'b1;
                        o_step.kind = TK_EQUALS;
                    end
                end else begin
                    o_step.emit = 1'b1;
                    case (c)
                        ";":     o_step.kind = TK_SEMI;
                        "+":     o_step.kind = TK_PLUS;
                        "*":     o_step.kind = TK_MUL;
                        "/":     o_step.kind = TK_DIV;
                        "-":     o_step.kind = TK_MINUS;
                        "(":     o_step.kind = TK_LPAREN;
                        ")":     o_step.kind = TK_RPAREN;
                        "{":     o_step.kind = TK_LBRACE;
                        "}":     o_step.kind = TK_RBRACE;
                        "<":     o_step.kind = TK_LESS;
                        ">":     o_step.kind = TK_GREATER;
                        "[":     o_step.kind = TK_LBRACKET;
                        "]":     o_step.kind = TK_RBRACKET;
                        ",":     o_step.kind = TK_COMMA;
                        default: o_step.kind = TK_UNKNOWN;
                    endcase
                end
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/script_keyword_tokenizer_core.sv */
// Top level of the script keyword tokenizer: pending window, run state,
// step sequencer and output register. Uses skt_pkg and skt_scan.
//
// Source bytes enter one item at a time and tokens leave as items with a
// source offset and length for variables, numbers and strings. An input item
// enters the pending window from the idle state, then the scan state takes
// settle steps on the window front (skip, keyword, operator, run byte or run
// end) until it sees the window settled or waiting for lookahead. A failed
// keyword prefix adds one step for each rescanned byte, plus one for each
// run that ends inside the window. After the final byte, the flush state
// emits any open run and the EOF state emits the EOF token. A step that
// emits waits while the output register is held by stall. The input stall
// is high whenever the sequencer is busy.
`default_nettype none
module script_keyword_tokenizer_core (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  wire  [7:0]          i_source_byte,
    input  wire                 i_end_of_source,
    output logic                o_valid,
    input  wire                 i_stall,
    output skt_pkg::t_kind      o_token_kind,
    output skt_pkg::t_off       o_value_offset,
    output skt_pkg::t_off       o_value_length,
    output logic                o_final_token
);
    import skt_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FLUSH, S_EOF} t_state;

    t_state r_state, n_state;
    t_win   r_win, n_win;
    t_cnt   r_count, n_count;
    t_run   r_mode, n_mode;
    t_off   r_start, n_start;
    t_off   r_len, n_len;
    t_off   r_offset, n_offset;
    t_off   r_cur, n_cur;
    logic   r_fin, n_fin;
    t_res   r_nres, n_nres;
    logic   r_o_valid, n_o_valid;
    t_kind  r_kind, n_kind;
    t_off   r_ooff, n_ooff;
    t_off   r_olen, n_olen;
    logic   r_ofin, n_ofin;

    t_step  step;
    t_off   front_off;
    t_off   back;
    logic   out_free;

    assign back      = t_off'(r_count - t_cnt'(1));
    assign front_off = (back > r_cur) ? '0 : r_cur - back;
    assign out_free  = !r_o_valid || !i_stall;

    skt_scan u_scan (
        .i_win       (r_win),
        .i_count     (r_count),
        .i_closed    (r_fin || (r_count >= t_cnt'(WINDOW_BYTES))),
        .i_mode      (r_mode),
        .i_start     (r_start),
        .i_len       (r_len),
        .i_front_off (front_off),
        .o_step      (step)
    );

    always_comb begin
        logic             want;
        logic             room;
        logic [IDX_BITS-1:0] idx;
        n_state   = r_state;
        n_win     = r_win;
        n_count   = r_count;
        n_mode    = r_mode;
        n_start   = r_start;
        n_len     = r_len;
        n_offset  = r_offset;
        n_cur     = r_cur;
        n_fin     = r_fin;
        n_nres    = r_nres;
        n_o_valid = r_o_valid && i_stall;
        n_kind    = r_kind;
        n_ooff    = r_ooff;
        n_olen    = r_olen;
        n_ofin    = r_ofin;
        want      = 1'b0;
        room      = r_nres < t_res'(MAX_RESULTS);
        idx       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (r_count >= t_cnt'(WINDOW_BYTES)) begin
                        idx     = IDX_BITS'(WINDOW_BYTES - 1);
                        n_count = t_cnt'(WINDOW_BYTES);
                    end else begin
                        idx     = r_count[IDX_BITS-1:0];
                        n_count = r_count + t_cnt'(1);
                    end
                    n_win[8*idx +: 8] = i_source_byte;
                    n_cur    = r_offset;
                    n_offset = sat_inc(r_offset);
                    n_fin    = i_end_of_source;
                    n_nres   = '0;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                if ((r_count == '0) || !step.adv) begin
                    n_state = r_fin ? S_FLUSH : S_IDLE;
                end else begin
                    want = step.emit && room;
                    if (!want || out_free) begin
                        n_win   = r_win >> {step.pop, 3'b000};
                        n_count = (step.pop > r_count) ? '0 : r_count - step.pop;
                        n_mode  = step.mode;
                        n_start = step.start;
                        n_len   = step.run_len;
                        if (want) begin
                            n_o_valid = 1'b1;
                            n_kind    = step.kind;
                            n_ooff    = step.off;
                            n_olen    = step.len;
                            n_ofin    = 1'b0;
                            n_nres    = r_nres + t_res'(1);
                        end
                    end
                end
            end
            S_FLUSH: begin
                want = (r_mode != RUN_NONE) && room;
                if (!want) begin
                    n_state = S_EOF;
                end else if (out_free) begin
                    n_o_valid = 1'b1;
                    case (r_mode)
                        RUN_VAR: n_kind = TK_VARIABLE;
                        RUN_NUM: n_kind = TK_NUMBER;
                        default: n_kind = TK_STRING;
                    endcase
                    n_ooff  = r_start;
                    n_olen  = r_len;
                    n_ofin  = 1'b0;
                    n_nres  = r_nres + t_res'(1);
                    n_state = S_EOF;
                end
            end
            S_EOF: begin
                want = room;
                if (!want || out_free) begin
                    if (want) begin
                        n_o_valid = 1'b1;
                        n_kind    = TK_EOF;
                        n_ooff    = '0;
                        n_olen    = '0;
                        n_ofin    = 1'b1;
                        n_nres    = r_nres + t_res'(1);
                    end
                    // stream over: back to reset values
                    n_count  = '0;
                    n_mode   = RUN_NONE;
                    n_start  = '0;
                    n_len    = '0;
                    n_offset = '0;
                    n_fin    = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_win  <= n_win;
        r_cur  <= n_cur;
        r_kind <= n_kind;
        r_ooff <= n_ooff;
        r_olen <= n_olen;
        r_ofin <= n_ofin;
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_mode    <= RUN_NONE;
            r_start   <= '0;
            r_len     <= '0;
            r_offset  <= '0;
            r_fin     <= 1'b0;
            r_nres    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_mode    <= n_mode;
            r_start   <= n_start;
            r_len     <= n_len;
            r_offset  <= n_offset;
            r_fin     <= n_fin;
            r_nres    <= n_nres;
            r_o_valid <= n_o_valid;
        end
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_o_valid;
    assign o_token_kind   = r_kind;
    assign o_value_offset = r_ooff;
    assign o_value_length = r_olen;
    assign o_final_token  = r_ofin;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_cnt'(WINDOW_BYTES))
        else $error("pending count above window size");

    a_res_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nres <= t_res'(MAX_RESULTS))
        else $error("too many tokens for one item");

    a_final_is_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_final_token) |-> (o_token_kind == TK_EOF))
        else $error("final flag on a non-EOF token");

    a_eof_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EOF) && (n_state == S_IDLE)) |=>
            ((r_offset == '0) && (r_count == '0) && (r_mode == RUN_NONE)))
        else $error("stream state not cleared after EOF");

endmodule
`default_nettype wire

/* dv/tb.sv */
// Testbench for script_keyword_tokenizer_core: random and directed source
// streams, a token predictor in SystemVerilog and an in-order result check.
// Depends on rtl/skt_pkg.sv and rtl/script_keyword_tokenizer_core.sv.
`timescale 1ns / 1ps
module tb;
    import skt_pkg::*;

    typedef struct packed {
        logic [7:0] src;
        logic       last;
    } t_byte_item;

    typedef struct packed {
        t_kind kind;
        t_off  off;
        t_off  len;
        logic  fin;
    } t_token;

    localparam t_kind TK_ECHO = 5'd0;
    localparam t_kind TK_FOR  = 5'd1;
    localparam t_kind TK_IF   = 5'd2;
    localparam t_kind TK_ELSE = 5'd3;
    localparam t_kind TK_FOREACH = 5'd4;
    localparam t_kind TK_AS   = 5'd5;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte = 8'h20;
    logic       in_last = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_kind      out_kind;
    t_off       out_off;
    t_off       out_len;
    logic       out_fin;

    script_keyword_tokenizer_core i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_source_byte(in_byte), .i_end_of_source(in_last),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_token_kind(out_kind), .o_value_offset(out_off),
        .o_value_length(out_len), .o_final_token(out_fin)
    );

    initial forever #2 clk = ~clk;

    // predictor state
    logic [7:0] win_q[$];
    t_run       run_mode;
    t_off       run_start;
    t_off       run_len;
    t_off       next_off;
    int         step_tokens = 0;

    t_byte_item src_q[$];
    t_token     tokens_due[$];
    int         errors = 0;
    bit         quiet_tail = 0;
    bit         hold_long = 0;
    bit         sender_pause = 0;

    function automatic t_off off_inc(t_off a, int unsigned n);
        longint s;
        s = longint'(a) + n;
        return (s > longint'(OFFSET_MAX)) ? OFFSET_MAX : t_off'(s);
    endfunction

    function automatic bit c_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit c_alnum(logic [7:0] c);
        return c_digit(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit c_space(logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    // at most MAX_RESULTS tokens per input item; the rest are dropped
    function automatic void queue_token(t_kind k, t_off o, t_off l, logic f);
        t_token t;
        if (step_tokens >= MAX_RESULTS) return;
        t.kind = k; t.off = o; t.len = l; t.fin = f;
        tokens_due.push_back(t);
        step_tokens++;
    endfunction

    // 0 no, 1 yes, 2 wait
    function automatic int word_hit(string w, bit bound, bit closed);
        for (int i = 0; i < w.len(); i++) begin
            if (i >= win_q.size()) return closed ? 0 : 2;
            if (win_q[i] != w[i]) return 0;
        end
        if (!bound) return 1;
        if (w.len() >= win_q.size()) return closed ? 1 : 2;
        return c_alnum(win_q[w.len()]) ? 0 : 1;
    endfunction

    function automatic int settle_front(bit closed, t_off off);
        string kw[6];
        t_kind kw_kind[6];
        logic [7:0] c;
        int r;
        t_kind k;
        kw = '{"echo", "for", "if", "else", "foreach", "as"};
        kw_kind = '{TK_ECHO, TK_FOR, TK_IF, TK_ELSE, TK_FOREACH, TK_AS};
        c = win_q[0];
        if (c_space(c)) return 1;
        r = word_hit("<?php", 0, closed);
        if (r == 2) return 0;
        if (r == 1) return 5;
        for (int i = 0; i < 6; i++) begin
            r = word_hit(kw[i], 1, closed);
            if (r == 2) return 0;
            if (r == 1) begin
                queue_token(kw_kind[i], '0, '0, 1'b0);
                return kw[i].len();
            end
        end
        if (c == "$") begin
            run_mode = RUN_VAR; run_start = off_inc(off, 1); run_len = '0; return 1;
        end
        if (c_digit(c)) begin
            run_mode = RUN_NUM; run_start = off; run_len = t_off'(1); return 1;
        end
        if (c == "\"") begin
            run_mode = RUN_STR; run_start = off_inc(off, 1); run_len = '0; return 1;
        end
        if (c == "=") begin
            if (win_q.size() < 2) begin
                if (!closed) return 0;
                queue_token(TK_EQUALS, '0, '0, 1'b0);
                return 1;
            end
            if (win_q[1] == ">") begin
                queue_token(TK_ARROW, '0, '0, 1'b0);
                return 2;
            end
            queue_token(TK_EQUALS, '0, '0, 1'b0);
            return 1;
        end
        case (c)
            ";": k = TK_SEMI;
            "+": k = TK_PLUS;
            "*": k = TK_MUL;
            "/": k = TK_DIV;
            "-": k = TK_MINUS;
            "(": k = TK_LPAREN;
            ")": k = TK_RPAREN;
            "{": k = TK_LBRACE;
            "}": k = TK_RBRACE;
            "<": k = TK_LESS;
            ">": k = TK_GREATER;
            "[": k = TK_LBRACKET;
            "]": k = TK_RBRACKET;
            ",": k = TK_COMMA;
            default: k = TK_UNKNOWN;
        endcase
        queue_token(k, '0, '0, 1'b0);
        return 1;
    endfunction

    function automatic void clear_stream();
        win_q.delete();
        run_mode = RUN_NONE;
        run_start = '0;
        run_len = '0;
        next_off = '0;
    endfunction

    function automatic void predict_tokens(t_byte_item it);
        t_off cur;
        int back;
        t_off front_off;
        int used;
        logic [7:0] f;
        step_tokens = 0;
        cur = next_off;
        next_off = off_inc(next_off, 1);
        if (win_q.size() >= WINDOW_BYTES) void'(win_q.pop_back());
        win_q.push_back(it.src);
        while (win_q.size() > 0) begin
            back = win_q.size() - 1;
            front_off = (back > cur) ? t_off'(0) : t_off'(cur - back);
            f = win_q[0];
            if (run_mode == RUN_STR) begin
                if (f == "\"") begin
                    queue_token(TK_STRING, run_start, run_len, 1'b0);
                    run_mode = RUN_NONE;
                end else begin
                    run_len = off_inc(run_len, 1);
                end
                void'(win_q.pop_front());
                continue;
            end
            if (run_mode != RUN_NONE) begin
                if ((run_mode == RUN_VAR) ? c_alnum(f) : c_digit(f)) begin
                    run_len = off_inc(run_len, 1);
                    void'(win_q.pop_front());
                    continue;
                end
                queue_token((run_mode == RUN_VAR) ? TK_VARIABLE : TK_NUMBER,
                            run_start, run_len, 1'b0);
                run_mode = RUN_NONE;
                continue;
            end
            used = settle_front(it.last || win_q.size() >= WINDOW_BYTES, front_off);
            if (used == 0) break;
            repeat (used) void'(win_q.pop_front());
        end
        if (it.last) begin
            if (run_mode == RUN_VAR) queue_token(TK_VARIABLE, run_start, run_len, 1'b0);
            else if (run_mode == RUN_NUM) queue_token(TK_NUMBER, run_start, run_len, 1'b0);
            else if (run_mode == RUN_STR) queue_token(TK_STRING, run_start, run_len, 1'b0);
            queue_token(TK_EOF, '0, '0, 1'b1);
            clear_stream();
        end
    endfunction

    // driver: bursts of idle on the input side
    int src_gap = 0;
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                predict_tokens('{src: in_byte, last: in_last});
            end
            if (!in_valid || !in_stall) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    in_valid <= 1'b0;
                end else if (src_q.size() > 0 && !sender_pause) begin
                    in_valid <= 1'b1;
                    {in_byte, in_last} <= src_q.pop_front();
                    if (!quiet_tail && $urandom_range(0, 7) == 0)
                        src_gap <= $urandom_range(1, 9);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stall
    int sink_gap = 0;
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (tokens_due.size() == 0) begin
                    $error("unexpected token kind %0d", out_kind);
                    errors++;
                end else begin
                    t_token e;
                    e = tokens_due.pop_front();
                    if (out_kind !== e.kind) begin
                        $error("token_kind exp %0d got %0d", e.kind, out_kind); errors++;
                    end
                    if (out_off !== e.off) begin
                        $error("value_offset exp %0d got %0d", e.off, out_off); errors++;
                    end
                    if (out_len !== e.len) begin
                        $error("value_length exp %0d got %0d", e.len, out_len); errors++;
                    end
                    if (out_fin !== e.fin) begin
                        $error("final_token exp %0d got %0d", e.fin, out_fin); errors++;
                    end
                end
            end
            if (hold_long) begin
                out_stall <= 1'b1;
            end else if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                out_stall <= 1'b1;
            end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                sink_gap <= $urandom_range(0, 8);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic push_text(string s, bit end_it);
        for (int i = 0; i < s.len(); i++)
            src_q.push_back('{src: s[i], last: end_it && i == s.len() - 1});
    endtask

    task automatic push_random_stream(int n);
        string pieces[] = '{"echo ", "for(", "if ", "else{", "foreach ", " as ", "$ab1",
                            "123", "\"hi x\"", "=>", "=", ";", "+", "*", "/", "-",
                            "()", "{}", "<", ">", "[]", ",", "<?php ", "ech", "fore",
                            "iff", "a", "\t\n", "elsex", "$", "\""};
        int made;
        string p;
        made = 0;
        while (made < n) begin
            if ($urandom_range(0, 5) == 0) begin
                src_q.push_back('{src: 8'($urandom_range(1, 255)), last: 1'b0});
                made++;
            end else begin
                p = pieces[$urandom_range(0, pieces.size() - 1)];
                push_text(p, 0);
                made += p.len();
            end
        end
        src_q.push_back('{src: 8'($urandom_range(1, 255)), last: 1'b1});
    endtask

    task automatic wait_drained();
        while (src_q.size() > 0 || in_valid || tokens_due.size() > 0) @(posedge clk);
    endtask

    initial begin
        clear_stream();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        // directed: keywords, boundaries, operators, runs, end cases
        push_text("<?php echo for if else foreach as;", 0);
        push_text(" $v9=>7+*/-(){}<>[],\"s\" echox", 0);
        src_q.push_back('{src: 8'hff, last: 1'b0});
        src_q.push_back('{src: 8'h80, last: 1'b0});
        src_q.push_back('{src: 8'h01, last: 1'b0});
        push_text("\"open", 1);
        push_text("foreach", 1);
        push_text("=", 1);
        push_text("$x", 1);
        push_text("42", 1);
        // long receiver hold while sender keeps offering
        push_random_stream(40);
        hold_long = 1;
        repeat (300) @(posedge clk);
        hold_long = 0;
        wait_drained();
        // sender pause until everything has come out
        sender_pause = 1;
        wait_drained();
        sender_pause = 0;
        for (int s = 0; s < 10; s++) push_random_stream($urandom_range(10, 40));
        wait_drained();
        quiet_tail = 1;
        push_random_stream(60);
        wait_drained();
        repeat (40) @(posedge clk);
        if (errors == 0 && tokens_due.size() == 0) begin
            $display("script_keyword_tokenizer_core verification clean");
        end else begin
            $display("script_keyword_tokenizer_core verification failed");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("script_keyword_tokenizer_core verification failed");
        $finish;
    end
endmodule

/* files.f */
rtl/skt_pkg.sv
rtl/skt_scan.sv
rtl/script_keyword_tokenizer_core.sv
dv/tb.sv
